FILE: rtl/tcba_pkg.sv
// tcba_pkg: shared types and codes of the two-class buffer allocator
// result status codes, configuration register indexes, stack shift control
// no dependencies
package tcba_pkg;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_REJECTED  = 3'd4
  } tcba_status_e;

  typedef enum logic {
    REG_SMALL_LIMIT = 1'b0,
    REG_LARGE_LIMIT = 1'b1
  } tcba_reg_e;

  localparam logic [31:0] SmallLimitReset = 32'd65536;
  localparam logic [31:0] LargeLimitReset = 32'd16777216;

  // shift control handed to every cell of a stack
  typedef struct packed {
    logic push;
    logic pop;
  } tcba_shift_t;

endpackage

FILE: rtl/tcba_cell.sv
// tcba_cell: one entry of a shifting free-index stack
// depends on tcba_pkg for the shift control struct
module tcba_cell import tcba_pkg::*; #(
  parameter int unsigned    IW        = 6,
  parameter logic [IW-1:0]  RESET_VAL = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tcba_shift_t   shift_i,
  input  logic [IW-1:0] above_i,
  input  logic [IW-1:0] below_i,
  output logic [IW-1:0] val_o
);

  logic [IW-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (shift_i.push) begin
      val_d = above_i;
    end else if (shift_i.pop) begin
      val_d = below_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= RESET_VAL;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

FILE: rtl/tcba_stack.sv
// tcba_stack: LIFO of free indices as a chain of tcba_cell, top at cell 0
// depends on tcba_pkg and tcba_cell
module tcba_stack import tcba_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tcba_shift_t   shift_i,
  input  logic [IW-1:0] push_val_i,
  output logic [IW-1:0] top_o,
  output logic          empty_o,
  output logic          full_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [IW-1:0] vals [DEPTH];
  logic [CW-1:0] count_q, count_d;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [IW-1:0] above, below;
    if (k == 0) begin : g_top
      assign above = push_val_i;
    end else begin : g_mid
      assign above = vals[k-1];
    end
    if (k == DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_nbot
      assign below = vals[k+1];
    end
    // reset full: highest index on top
    tcba_cell #(
      .IW        (IW),
      .RESET_VAL (IW'(DEPTH - 1 - k))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_i),
      .above_i (above),
      .below_i (below),
      .val_o   (vals[k])
    );
  end

  always_comb begin
    count_d = count_q;
    if (shift_i.push) begin
      count_d = count_q + 1'b1;
    end else if (shift_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CW'(DEPTH);
    end else begin
      count_q <= count_d;
    end
  end

  assign top_o   = vals[0];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));

endmodule

FILE: rtl/two_class_buffer_allocator_unit.sv
// two_class_buffer_allocator_unit: top level of the two-class buffer allocator
// depends on tcba_pkg, tcba_stack, tcba_cell
//
// channel   direction  handshake                     payload
// request   in         start high, busy low          kind, request_size, release class/index
// result    out        done_o high for one cycle     status, granted_class, granted_index
// config    in         apb write, psel&penable       small/large size limits at 0x0 / 0x4
//
// one item per cycle: a transfer at one edge has its result on the ports for the
// following cycle, and busy stays low, so requests may arrive back to back
// the rate is set by the shift of the cell chains, which pop or push
// the whole stack in a single step together with the two size compares
// after reset both stacks are full, highest index on top; limits take their reset values
// no clearing pass is needed: every cell resets to its own entry
// the receiver cannot stall; each result is taken in the cycle it is shown
module two_class_buffer_allocator_unit import tcba_pkg::*; #(
  parameter int unsigned SMALL_COUNT = 64,
  parameter int unsigned LARGE_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [31:0] request_size_i,
  input  logic        release_class_i,
  input  logic [5:0]  release_index_i,
  // result channel
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        granted_class_o,
  output logic [5:0]  granted_index_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SIW = (SMALL_COUNT > 1) ? $clog2(SMALL_COUNT) : 1;
  localparam int unsigned LIW = (LARGE_COUNT > 1) ? $clog2(LARGE_COUNT) : 1;

  // configuration registers
  logic [31:0] small_lim_q, large_lim_q;
  logic        cfg_wr;
  tcba_reg_e   cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_reg = tcba_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_lim_q <= SmallLimitReset;
      large_lim_q <= LargeLimitReset;
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_SMALL_LIMIT: small_lim_q <= pwdata;
        REG_LARGE_LIMIT: large_lim_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_SMALL_LIMIT: prdata = small_lim_q;
      REG_LARGE_LIMIT: prdata = large_lim_q;
      default:         prdata = '0;
    endcase
  end

  // stacks
  tcba_shift_t    small_shift, large_shift;
  logic [SIW-1:0] small_top, small_push;
  logic [LIW-1:0] large_top, large_push;
  logic           small_empty, small_full, large_empty, large_full;
  logic [15:0]    ridx_ext;

  // release index widened then cut to each class's index width
  assign ridx_ext   = {10'd0, release_index_i};
  assign small_push = ridx_ext[SIW-1:0];
  assign large_push = ridx_ext[LIW-1:0];

  tcba_stack #(.DEPTH(SMALL_COUNT), .IW(SIW)) u_small (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (small_shift),
    .push_val_i (small_push),
    .top_o      (small_top),
    .empty_o    (small_empty),
    .full_o     (small_full)
  );

  tcba_stack #(.DEPTH(LARGE_COUNT), .IW(LIW)) u_large (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_i    (large_shift),
    .push_val_i (large_push),
    .top_o      (large_top),
    .empty_o    (large_empty),
    .full_o     (large_full)
  );

  // request decode
  logic         accept;
  logic         fits_small, fits_large;
  logic         small_oor, large_oor;
  logic [15:0]  small_top_ext, large_top_ext;
  tcba_status_e status_d;
  logic         class_d;
  logic [5:0]   index_d;

  assign busy          = 1'b0;
  assign accept        = start & ~busy;
  assign fits_small    = (request_size_i <= small_lim_q);
  assign fits_large    = (request_size_i <= large_lim_q);
  assign small_oor     = (int'(release_index_i) >= SMALL_COUNT);
  assign large_oor     = (int'(release_index_i) >= LARGE_COUNT);
  assign small_top_ext = 16'(small_top);
  assign large_top_ext = 16'(large_top);

  always_comb begin
    small_shift = '0;
    large_shift = '0;
    status_d    = ST_GRANTED;
    class_d     = 1'b0;
    index_d     = '0;
    if (!kind_i) begin
      // acquire: small limit tested first, no fallback between classes
      if (fits_small) begin
        if (small_empty) begin
          status_d = ST_EMPTY;
        end else begin
          small_shift.pop = accept;
          index_d         = small_top_ext[5:0];
        end
      end else if (fits_large) begin
        if (large_empty) begin
          status_d = ST_EMPTY;
        end else begin
          large_shift.pop = accept;
          class_d         = 1'b1;
          index_d         = large_top_ext[5:0];
        end
      end else begin
        status_d = ST_TOO_LARGE;
      end
    end else begin
      // release: reject out-of-range index or full stack
      if (!release_class_i) begin
        if (small_oor || small_full) begin
          status_d = ST_REJECTED;
        end else begin
          status_d         = ST_RELEASED;
          small_shift.push = accept;
        end
      end else begin
        if (large_oor || large_full) begin
          status_d = ST_REJECTED;
        end else begin
          status_d         = ST_RELEASED;
          large_shift.push = accept;
        end
      end
    end
  end

  // result register
  logic         done_q;
  tcba_status_e status_q;
  logic         class_q;
  logic [5:0]   index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      class_q  <= class_d;
      index_q  <= index_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign granted_class_o = class_q;
  assign granted_index_o = index_q;

endmodule

FILE: rtl/tcba_checker.sv
// tcba_checker: port-level assertions for two_class_buffer_allocator_unit
// depends on tcba_pkg; bound to the top level at the end of this file
module tcba_checker import tcba_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        kind_i,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic        granted_class_o,
  input logic [5:0]  granted_index_o
);

  // every accepted transfer gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> done_o)
    else $error("accepted transfer without result");

  // no result without an accepted transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && rst_ni))
    else $error("result without accepted transfer");

  // grant fields are zero unless granted
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_GRANTED |-> !granted_class_o && granted_index_o == '0)
    else $error("grant fields set on non-grant result");

  // release codes answer releases only
  a_kind_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_RELEASED || status_o == ST_REJECTED) |-> $past(kind_i))
    else $error("release status for an acquire");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o <= ST_REJECTED)
    else $error("status code out of range");

endmodule

bind two_class_buffer_allocator_unit tcba_checker u_tcba_checker (.*);
